[rtl/awmef_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package awmef_pkg;

	localparam int NUM_CHANNELS_DEF   = 8;
	localparam int WARMUP_SAMPLES_DEF = 16;

	localparam int CHAN_W    = 3;
	localparam int SAMPLE_W  = 12;
	localparam int VALUE_W   = 32;
	localparam int FRAC_W    = 16;
	// ema weight is (2^EMA_SHIFT - 1) / 2^EMA_SHIFT
	localparam int EMA_SHIFT = 8;

	typedef struct packed {
		logic [CHAN_W-1:0]   channel;
		logic [SAMPLE_W-1:0] sample;
		logic                sample_ok;
	} smp_req_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] filtered_value;
		logic                settled;
	} res_req_t;

	function automatic logic [SAMPLE_W-1:0] med3(
		input logic [SAMPLE_W-1:0] a,
		input logic [SAMPLE_W-1:0] b,
		input logic [SAMPLE_W-1:0] c
	);
		logic [SAMPLE_W-1:0] lo;
		logic [SAMPLE_W-1:0] hi;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		if (c <= lo) begin
			med3 = lo;
		end else if (c >= hi) begin
			med3 = hi;
		end else begin
			med3 = c;
		end
	endfunction

endpackage

`default_nettype wire

[rtl/awmef_div.sv]
`timescale 1ns / 1ps
`default_nettype none

// restoring divider, one quotient bit per cycle
module awmef_div import awmef_pkg::*; #(
	parameter int DVD_W = SAMPLE_W + 4 + FRAC_W,
	parameter int DVS_W = 5
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DVD_W-1:0] dividend,
	input  wire logic [DVS_W-1:0] divisor,
	output logic                  done,
	output logic      [DVD_W-1:0] quotient
);

	localparam int STEP_W = $clog2(DVD_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [DVD_W-1:0]  quo_q;
	logic [DVS_W-1:0]  rem_q;
	logic [DVS_W-1:0]  dvs_q;

	logic [DVS_W:0]   trial;
	logic             ge;
	logic [DVS_W-1:0] rem_nxt;

	always_comb begin
		trial   = {rem_q, quo_q[DVD_W-1]};
		ge      = (trial >= {1'b0, dvs_q});
		rem_nxt = ge ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(DVD_W);
			end else if (busy_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DVD_W-2:0], ge};
			rem_q <= rem_nxt;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

[rtl/adc_warmup_median_ema_filter.sv]
// result register loads from the execute state once the output is free, on the common path
// last warm-up sample: mean by reciprocal multiply in three stages
// bad sample during warm-up: bit-serial divide of the sum by the count
// one request in flight, next accepted once the sequencer is back in idle
// reset: arst_n asynchronous active low, clears control state and all per-channel valid bits
// so every channel starts from zero state, no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module adc_warmup_median_ema_filter import awmef_pkg::*; #(
	parameter int NUM_CHANNELS   = NUM_CHANNELS_DEF,
	parameter int WARMUP_SAMPLES = WARMUP_SAMPLES_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     smp_valid,
	output logic          smp_stall,
	input  wire smp_req_t smp,
	output logic          res_valid,
	input  wire logic     res_stall,
	output res_req_t      res
);

	// address, count and sum widths
	localparam int CH_AW   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int CNT_W   = $clog2(WARMUP_SAMPLES + 1);
	localparam int LOG_W   = $clog2(WARMUP_SAMPLES);
	localparam int SUM_W   = SAMPLE_W + LOG_W;
	localparam int ENTRY_W = VALUE_W + CNT_W + 2 * SAMPLE_W;
	localparam int EMA_W   = VALUE_W + EMA_SHIFT;

	// mean by reciprocal: integer part = sum / n, fraction = (rem << 16) / n
	localparam int K1 = SUM_W + LOG_W;
	localparam int N2 = LOG_W + FRAC_W;
	localparam int K2 = N2 + LOG_W;
	localparam logic [K1-1:0] RCP1 = K1'(((64'd1 << K1) + 64'(WARMUP_SAMPLES) - 64'd1)
		/ 64'(WARMUP_SAMPLES));
	localparam logic [K2-1:0] RCP2 = K2'(((64'd1 << K2) + 64'(WARMUP_SAMPLES) - 64'd1)
		/ 64'(WARMUP_SAMPLES));

	localparam logic [CNT_W-1:0] WARM_CNT = CNT_W'(WARMUP_SAMPLES);
	localparam logic [SUM_W-1:0] WARM_SUM = SUM_W'(WARMUP_SAMPLES);

	// sequencer codes
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_DIV  = 2'd2;
	localparam logic [1:0] S_FIN  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	// per-channel state memory: {running value, count, older, newer}
	logic [ENTRY_W-1:0] mem [NUM_CHANNELS];
	logic [ENTRY_W-1:0] rd_data_q;
	logic               rd_vld_q;
	logic [NUM_CHANNELS-1:0] vld_q;

	// captured request
	smp_req_t   item_q;
	logic       in_range_q;
	logic [CH_AW-1:0] addr_q;
	logic       mean_case_q;

	logic       res_valid_q;
	res_req_t   res_q;

	logic             smp_acc;
	logic [CH_AW-1:0] smp_addr;
	logic             smp_in_range;
	logic             out_free;

	// unpacked entry, invalid entries read as zero
	logic [ENTRY_W-1:0]  entry;
	logic [VALUE_W-1:0]  cur_v;
	logic [CNT_W-1:0]    cur_cnt;
	logic [SAMPLE_W-1:0] cur_old;
	logic [SAMPLE_W-1:0] cur_new;
	logic [SAMPLE_W-1:0] cur_int;

	logic                warm_done;
	logic [CNT_W-1:0]    cnt_inc;
	logic                last_warm;
	logic [VALUE_W-1:0]  sum_nxt;
	logic [SAMPLE_W-1:0] med;
	logic [EMA_W-1:0]    ema_acc;
	logic [VALUE_W-1:0]  ema_v;

	// divider hookup, partial mean only
	logic             div_start;
	logic             div_done;
	logic [SUM_W-1:0] div_dividend;
	logic [CNT_W-1:0] div_divisor;
	logic [SUM_W-1:0] div_quo;
	logic [VALUE_W-1:0]  mean_v;
	logic [SAMPLE_W-1:0] mean_int;

	// end-of-warm-up mean pipeline
	logic                   mean_start;
	logic                   mean_go_q;
	logic                   mean_vld_s1;
	logic                   mean_vld_s2;
	logic                   mean_vld_s3;
	logic [SUM_W-1:0]       mean_sum_q;
	logic [SAMPLE_W-1:0]    mean_int_s1;
	logic [LOG_W-1:0]       mean_rem_s2;
	logic [FRAC_W-1:0]      mean_frac_s3;
	logic [SUM_W+K1-1:0]    mean_p1;
	logic [N2+K2-1:0]       mean_p2;
	logic [SUM_W-1:0]       mean_diff;

	// per-state decisions
	logic               need_div;
	logic               emit_c;
	logic               wr_c;
	logic [ENTRY_W-1:0] wr_data_c;
	res_req_t           res_c;
	logic               emit_go;
	logic               wr_en;

	assign smp_acc      = smp_valid && !smp_stall;
	assign smp_addr     = CH_AW'(smp.channel);
	assign smp_in_range = (int'(smp.channel) < NUM_CHANNELS);
	assign out_free     = !res_valid_q || !res_stall;

	// one request in flight at a time
	assign smp_stall = (state_q != S_IDLE);

	always_comb begin
		entry   = rd_vld_q ? rd_data_q : '0;
		cur_v   = entry[ENTRY_W-1 -: VALUE_W];
		cur_cnt = entry[2*SAMPLE_W +: CNT_W];
		cur_old = entry[SAMPLE_W +: SAMPLE_W];
		cur_new = entry[0 +: SAMPLE_W];
		cur_int = cur_v[FRAC_W +: SAMPLE_W];
	end

	always_comb begin
		warm_done = (cur_cnt >= WARM_CNT);
		cnt_inc   = cur_cnt + CNT_W'(1);
		last_warm = (cnt_inc == WARM_CNT);
		sum_nxt   = cur_v + VALUE_W'(item_q.sample);
		med       = med3(cur_old, cur_new, item_q.sample);
		// v * 255 as (v << 8) - v, plus the median in 16.16, then >> 8
		ema_acc   = {cur_v, {EMA_SHIFT{1'b0}}} - {{EMA_SHIFT{1'b0}}, cur_v}
			+ EMA_W'({med, {FRAC_W{1'b0}}});
		ema_v     = ema_acc[EMA_W-1:EMA_SHIFT];
	end

	// bad sample during warm-up: partial mean = sum / count
	assign div_dividend = cur_v[SUM_W-1:0];
	assign div_divisor  = cur_cnt;

	// final mean = (sum << 16) / warm-up count, one multiply per stage
	always_comb begin
		mean_p1   = {{K1{1'b0}}, mean_sum_q} * {{SUM_W{1'b0}}, RCP1};
		mean_diff = mean_sum_q - SUM_W'(mean_int_s1) * WARM_SUM;
		mean_p2   = {{K2{1'b0}}, mean_rem_s2, {FRAC_W{1'b0}}} * {{N2{1'b0}}, RCP2};
	end

	assign mean_v   = VALUE_W'({mean_int_s1, mean_frac_s3});
	assign mean_int = mean_int_s1;

	always_comb begin
		need_div  = 1'b0;
		emit_c    = 1'b0;
		wr_c      = 1'b0;
		wr_data_c = {cur_v, cur_cnt, cur_old, cur_new};
		res_c     = '0;
		unique case (state_q)
			S_EXEC: begin
				emit_c = 1'b1;
				if (!in_range_q) begin
					// channel beyond the configured count: ignored
					res_c = '0;
				end else if (!item_q.sample_ok) begin
					// bad conversion, state untouched
					if (cur_cnt == '0) begin
						res_c = '0;
					end else if (!warm_done) begin
						need_div = 1'b1;
						emit_c   = 1'b0;
					end else begin
						res_c = '{filtered_value: cur_int, settled: 1'b1};
					end
				end else if (!warm_done) begin
					// warm-up: raw sample passes through, sum grows
					if (last_warm) begin
						need_div = 1'b1;
						emit_c   = 1'b0;
					end else begin
						wr_c      = 1'b1;
						wr_data_c = {sum_nxt, cnt_inc, cur_old, cur_new};
						res_c     = '{filtered_value: item_q.sample, settled: 1'b0};
					end
				end else if (item_q.sample != '0) begin
					// median of 3, then ema update
					wr_c      = 1'b1;
					wr_data_c = {ema_v, cur_cnt, cur_new, item_q.sample};
					res_c     = '{filtered_value: ema_v[FRAC_W +: SAMPLE_W], settled: 1'b1};
				end else begin
					// zero sample after warm-up leaves the state alone
					res_c = '{filtered_value: cur_int, settled: 1'b1};
				end
			end
			S_FIN: begin
				emit_c = 1'b1;
				if (mean_case_q) begin
					// end of warm-up: seed both history slots with the mean
					wr_c      = 1'b1;
					wr_data_c = {mean_v, WARM_CNT, mean_int, mean_int};
					res_c     = '{filtered_value: item_q.sample, settled: 1'b1};
				end else begin
					res_c = '{filtered_value: div_quo[SAMPLE_W-1:0], settled: 1'b0};
				end
			end
			S_IDLE, S_DIV: begin
				emit_c = 1'b0;
			end
			default: begin
				emit_c = 1'b0;
			end
		endcase
	end

	assign emit_go    = emit_c && out_free;
	assign wr_en      = emit_go && wr_c;
	assign div_start  = (state_q == S_EXEC) && need_div && !item_q.sample_ok;
	assign mean_start = (state_q == S_EXEC) && need_div && item_q.sample_ok;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (smp_acc) begin
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				if (need_div) begin
					state_nxt = S_DIV;
				end else if (out_free) begin
					state_nxt = S_IDLE;
				end
			end
			S_DIV: begin
				if (div_done || mean_vld_s3) begin
					state_nxt = S_FIN;
				end
			end
			S_FIN: begin
				if (out_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			vld_q       <= '0;
			rd_vld_q    <= 1'b0;
			res_valid_q <= 1'b0;
			mean_go_q   <= 1'b0;
			mean_vld_s1 <= 1'b0;
			mean_vld_s2 <= 1'b0;
			mean_vld_s3 <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (wr_en) begin
				vld_q[addr_q] <= 1'b1;
			end
			if (smp_acc) begin
				rd_vld_q <= smp_in_range && vld_q[smp_addr];
			end
			if (emit_go) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			mean_go_q   <= mean_start;
			mean_vld_s1 <= mean_go_q;
			mean_vld_s2 <= mean_vld_s1;
			mean_vld_s3 <= mean_vld_s2;
		end
	end

	// state memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr_q] <= wr_data_c;
		end
		if (smp_acc && smp_in_range) begin
			rd_data_q <= mem[smp_addr];
		end
	end

	// mean stages follow mean_sum_q, which holds until the next warm-up end
	always_ff @(posedge clk) begin
		if (mean_start) begin
			mean_sum_q <= sum_nxt[SUM_W-1:0];
		end
		mean_int_s1  <= mean_p1[K1 +: SAMPLE_W];
		mean_rem_s2  <= mean_diff[LOG_W-1:0];
		mean_frac_s3 <= mean_p2[K2 +: FRAC_W];
	end

	// request capture and result payload
	always_ff @(posedge clk) begin
		if (smp_acc) begin
			item_q     <= smp;
			in_range_q <= smp_in_range;
			addr_q     <= smp_addr;
		end
		if (div_start || mean_start) begin
			mean_case_q <= item_q.sample_ok;
		end
		if (emit_go) begin
			res_q <= res_c;
		end
	end

	awmef_div #(
		.DVD_W (SUM_W),
		.DVS_W (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire

[rtl/awmef_chk.sv]
`timescale 1ns / 1ps
`default_nettype none

module awmef_chk import awmef_pkg::*; (
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     smp_valid,
	input wire logic     smp_stall,
	input wire smp_req_t smp,
	input wire logic     res_valid,
	input wire logic     res_stall,
	input wire res_req_t res
);

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("stalled result changed or dropped");

	// one request at a time: busy right after an accept
	a_busy_after_acc: assert property (@(posedge clk) disable iff (!arst_n)
		smp_valid && !smp_stall |=> smp_stall)
		else $error("request accepted while previous one in work");

	// a new result only comes out of a request in work
	a_res_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(smp_stall))
		else $error("result without a request in work");

	// result taken while idle: nothing follows until a new request
	a_settle_needs_req: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_stall && !smp_stall |=> !res_valid)
		else $error("result produced with no request in work");

endmodule

bind adc_warmup_median_ema_filter awmef_chk u_awmef_chk (.*);

`default_nettype wire

[tb/tb_adc_warmup_median_ema_filter.sv]
`timescale 1ns / 1ps

module tb_adc_warmup_median_ema_filter;
	import awmef_pkg::*;

	localparam int NCH          = NUM_CHANNELS_DEF;
	localparam int WARM         = WARMUP_SAMPLES_DEF;
	localparam int RANDOM_ITEMS = 1600;
	// no idling once this few requests are left
	localparam int TAIL         = 200;
	// long receiver hold-off, starts after this many results
	localparam int HOLD_AT      = 400;
	localparam int HOLD_LEN     = 400;
	// mid-run sender pause, placed at about this random request
	localparam int PAUSE_AT     = 900;
	// cycles with no handshake on either side before giving up
	localparam int STALL_LIMIT  = 3000;
	// partial-mean divide is the slowest path
	localparam int SETTLE_CYCLES = 80;

	typedef struct {
		smp_req_t req;
		bit       drain_first;
	} pending_t;

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     smp_valid = 1'b0;
	logic     smp_stall;
	smp_req_t smp       = '0;
	logic     res_valid;
	logic     res_stall = 1'b0;
	res_req_t res;

	// requests waiting to be offered, and results still owed by the block
	pending_t pending[$];
	res_req_t filtered_expect[$];

	int total_items = 0;
	int sent_cnt    = 0;
	int got_cnt     = 0;
	int err_cnt     = 0;
	int still_cycles = 0;

	// per-channel filter state as the block should hold it
	logic [31:0] ema_acc  [NCH] = '{default: '0};
	logic [4:0]  warm_cnt [NCH] = '{default: '0};
	logic [11:0] hist_old [NCH] = '{default: '0};
	logic [11:0] hist_new [NCH] = '{default: '0};

	adc_warmup_median_ema_filter uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.smp_valid (smp_valid),
		.smp_stall (smp_stall),
		.smp       (smp),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// advance the channel state by one request and return what the block should answer
	function automatic res_req_t filter_predict(input smp_req_t s);
		res_req_t    r;
		int unsigned ch;
		logic [4:0]  cnt;
		logic [31:0] quot;
		logic [63:0] mean;
		logic [63:0] acc;
		logic [11:0] a;
		logic [11:0] b;
		logic [11:0] c;
		logic [11:0] mid;
		r = '0;
		ch = s.channel;
		// channels above the configured count leave everything alone
		if (ch < NCH) begin
			cnt = warm_cnt[ch];
			if (!s.sample_ok) begin
				// bad conversion: report without touching state
				if (cnt == 0) begin
					r.filtered_value = '0;
				end else if (cnt < WARM) begin
					quot = ema_acc[ch] / 32'(cnt);
					r.filtered_value = quot[11:0];
				end else begin
					r.filtered_value = ema_acc[ch][27:16];
					r.settled = 1'b1;
				end
			end else if (cnt < WARM) begin
				// warm-up: plain sum, raw sample passes through
				ema_acc[ch] = ema_acc[ch] + 32'(s.sample);
				cnt = cnt + 5'd1;
				warm_cnt[ch] = cnt;
				if (cnt == WARM) begin
					// sum becomes the 16.16 mean, history seeded with its integer part
					mean = (64'(ema_acc[ch]) << 16) / 64'(WARM);
					ema_acc[ch] = mean[31:0];
					hist_old[ch] = mean[27:16];
					hist_new[ch] = mean[27:16];
					r.settled = 1'b1;
				end
				r.filtered_value = s.sample;
			end else begin
				r.settled = 1'b1;
				// a zero sample after warm-up is dropped
				if (s.sample != '0) begin
					a = hist_old[ch];
					b = hist_new[ch];
					c = s.sample;
					if ((a <= c && c <= b) || (b <= c && c <= a)) begin
						mid = c;
					end else if ((c <= a && a <= b) || (b <= a && a <= c)) begin
						mid = a;
					end else begin
						mid = b;
					end
					hist_old[ch] = b;
					hist_new[ch] = c;
					// ema with weight 255/256, truncated
					acc = (64'(mid) << 16) + 64'(ema_acc[ch]) * 64'd255;
					ema_acc[ch] = acc[39:8];
				end
				r.filtered_value = ema_acc[ch][27:16];
			end
		end
		return r;
	endfunction

	task automatic queue_request(input logic [2:0] ch, input logic [11:0] val, input logic ok,
		input bit drain);
		pending_t p;
		p.req.channel = ch;
		p.req.sample = val;
		p.req.sample_ok = ok;
		p.drain_first = drain;
		pending.push_back(p);
	endtask

	// stimulus: directed requests, then random ones, then wait for the block to drain
	initial begin
		int          n;
		int          k;
		int          len;
		int          kind;
		int          lvl;
		int          target;
		logic [2:0]  ch;
		logic [11:0] v;
		logic        ok;
		bit          paused;
		logic [11:0] level [NCH];

		for (k = 0; k < NCH; k++) begin
			level[k] = 12'd2048;
		end

		// directed: channel 0 through its whole life, then the top channel
		queue_request(3'd0, 12'hfff, 1'b0, 1'b0);      // bad conversion before any sample
		queue_request(3'd0, 12'hfff, 1'b1, 1'b0);
		queue_request(3'd0, 12'h000, 1'b1, 1'b0);      // zero counted during warm-up
		queue_request(3'd0, 12'h000, 1'b0, 1'b0);      // partial mean
		for (k = 0; k < WARM - 3; k++) begin
			queue_request(3'd0, (k % 2 == 0) ? 12'hfff : 12'(k * 300), 1'b1, 1'b0);
		end
		queue_request(3'd0, 12'h555, 1'b0, 1'b0);      // partial mean just before the end
		queue_request(3'd0, 12'hfff, 1'b1, 1'b0);      // last warm-up sample
		queue_request(3'd0, 12'h000, 1'b1, 1'b0);      // zero after warm-up is dropped
		queue_request(3'd0, 12'hfff, 1'b1, 1'b0);
		queue_request(3'd0, 12'h001, 1'b1, 1'b0);
		queue_request(3'd0, 12'haaa, 1'b0, 1'b0);      // bad conversion after warm-up
		queue_request(3'd7, 12'h000, 1'b0, 1'b0);      // fresh top channel, bad conversion
		queue_request(3'd7, 12'hfff, 1'b1, 1'b0);

		// random part, first request waits for the directed results to drain
		n = 0;
		paused = 1'b0;
		while (n < RANDOM_ITEMS) begin
			if ($urandom_range(0, 99) < 3) begin
				// steady run on one channel so the ema gets near its input
				ch = 3'($urandom_range(0, NCH - 1));
				case ($urandom_range(0, 2))
					0: begin
						target = 4095;
					end
					1: begin
						target = 1;
					end
					default: begin
						target = $urandom_range(1, 4095);
					end
				endcase
				len = $urandom_range(20, 60);
				for (k = 0; k < len; k++) begin
					queue_request(ch, 12'(target), 1'b1, n == 0);
					n++;
				end
				level[ch] = 12'(target);
			end else begin
				ch = 3'($urandom_range(0, NCH - 1));
				kind = $urandom_range(0, 99);
				ok = 1'b1;
				if (kind < 8) begin
					ok = 1'b0;
					v = 12'($urandom);
				end else if (kind < 14) begin
					v = '0;
				end else if (kind < 20) begin
					v = $urandom_range(0, 1) ? 12'hfff : 12'h001;
				end else if (kind < 55) begin
					// small wander around the channel level
					lvl = int'(level[ch]) + int'($urandom_range(0, 64)) - 32;
					if (lvl < 1) lvl = 1;
					if (lvl > 4095) lvl = 4095;
					v = 12'(lvl);
				end else begin
					v = 12'($urandom);
				end
				if (ok && v != '0) begin
					level[ch] = v;
				end
				queue_request(ch, v, ok, n == 0 || (!paused && n >= PAUSE_AT));
				if (n >= PAUSE_AT) begin
					paused = 1'b1;
				end
				n++;
			end
		end
		total_items = pending.size();

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (pending.size() != 0 || smp_valid || got_cnt != sent_cnt) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (filtered_expect.size() != 0) begin
			$display("error: %0d results never arrived", filtered_expect.size());
		end
		if (err_cnt == 0 && filtered_expect.size() == 0) begin
			$display("adc_warmup_median_ema_filter verification clean");
		end else begin
			$display("adc_warmup_median_ema_filter verification failed");
		end
		$finish;
	end

	// sample side: offer pending requests, predict each one as it is taken
	int tx_gap  = 0;
	int tx_mode = 0;
	int tx_tick = 0;

	always @(posedge clk or negedge arst_n) begin : sample_driver
		logic took;
		logic offer;
		int   nsent;
		if (!arst_n) begin
			smp_valid <= 1'b0;
			smp <= '0;
			sent_cnt <= 0;
			tx_gap <= 0;
			tx_mode <= 0;
			tx_tick <= 0;
		end else begin
			took = smp_valid && !smp_stall;
			nsent = sent_cnt + (took ? 1 : 0);
			if (took) begin
				filtered_expect.push_back(filter_predict(smp));
			end
			// idling intensity changes now and then, mode zero means back-to-back
			tx_tick <= tx_tick + 1;
			if (tx_tick % 128 == 0) begin
				tx_mode <= $urandom_range(0, 3);
			end
			// payload only moves once the current request is gone
			if (!smp_valid || took) begin
				offer = 1'b0;
				if (tx_gap != 0) begin
					tx_gap <= tx_gap - 1;
				end else if (pending.size() != 0 &&
					(!pending[0].drain_first || got_cnt == nsent)) begin
					if (tx_mode != 0 && nsent + TAIL < total_items &&
						$urandom_range(0, 1 << tx_mode) == 0) begin
						// random idle gap before the next offer
						tx_gap <= $urandom_range(0, 5);
					end else begin
						smp <= pending[0].req;
						pending.pop_front();
						offer = 1'b1;
					end
				end
				smp_valid <= offer;
			end
			sent_cnt <= nsent;
		end
	end

	// result side: random stall bursts plus one long hold-off to back the block up
	int  rx_burst  = 0;
	int  rx_mode   = 0;
	int  rx_tick   = 0;
	int  hold_left = 0;
	bit  hold_done = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
			rx_burst <= 0;
			rx_mode <= 0;
			rx_tick <= 0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else begin
			rx_tick <= rx_tick + 1;
			if (rx_tick % 96 == 0) begin
				rx_mode <= $urandom_range(0, 3);
			end
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				res_stall <= 1'b1;
			end else if (!hold_done && got_cnt >= HOLD_AT) begin
				hold_left <= HOLD_LEN - 1;
				hold_done <= 1'b1;
				res_stall <= 1'b1;
			end else if (rx_burst != 0) begin
				rx_burst <= rx_burst - 1;
				res_stall <= 1'b1;
			end else if (rx_mode != 0 && got_cnt + TAIL < total_items &&
				$urandom_range(0, 1 << rx_mode) == 0) begin
				rx_burst <= $urandom_range(0, 5);
				res_stall <= 1'b1;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	// compare every taken result with the oldest prediction
	always @(posedge clk or negedge arst_n) begin : result_monitor
		res_req_t want;
		if (!arst_n) begin
			got_cnt <= 0;
		end else if (res_valid && !res_stall) begin
			got_cnt <= got_cnt + 1;
			if (filtered_expect.size() == 0) begin
				err_cnt++;
				if (err_cnt <= 10) begin
					$display("error: unexpected result value %0d settled %0b at %0t",
						res.filtered_value, res.settled, $realtime);
				end
			end else begin
				want = filtered_expect.pop_front();
				if (res.filtered_value !== want.filtered_value ||
					res.settled !== want.settled) begin
					err_cnt++;
					if (err_cnt <= 10) begin
						$display("error: result %0d expected value %0d settled %0b, got value %0d settled %0b",
							got_cnt, want.filtered_value, want.settled,
							res.filtered_value, res.settled);
					end
				end
			end
		end
	end

	// watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((smp_valid && !smp_stall) || (res_valid && !res_stall)) begin
				still_cycles <= 0;
			end else if (still_cycles >= STALL_LIMIT) begin
				$display("error: no progress for %0d cycles", STALL_LIMIT);
				$display("adc_warmup_median_ema_filter verification failed");
				$finish;
			end else begin
				still_cycles <= still_cycles + 1;
			end
		end
	end

endmodule

[files.f]
rtl/awmef_pkg.sv
rtl/awmef_div.sv
rtl/adc_warmup_median_ema_filter.sv
rtl/awmef_chk.sv
tb/tb_adc_warmup_median_ema_filter.sv
